[rtl/smf_pkg.sv]
// Shared types and constants for the track event byte parser.
// Holds the parser phase encoding, field kind codes and the VLQ byte budget.
// No dependencies.
package smf_pkg;

	// Longest variable-length quantity, in bytes.
	localparam int unsigned VLQ_MAX_BYTES = 4;

	localparam int unsigned VAL_W    = 28;
	localparam int unsigned KIND_W   = 3;
	localparam int unsigned TDATA_W  = 64;
	localparam int unsigned TUSER_W  = 4;

	// Field kind codes carried with each result item.
	localparam logic [KIND_W-1:0] KIND_DELTA   = 3'd0;
	localparam logic [KIND_W-1:0] KIND_STATUS  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_META    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_LENGTH  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd4;

	// Status byte values with a fixed meaning.
	localparam logic [7:0] ST_META      = 8'hFF;
	localparam logic [7:0] ST_SYSEX     = 8'hF0;
	localparam logic [7:0] ST_SYSEX_ESC = 8'hF7;
	localparam logic [3:0] HI_PROGRAM   = 4'hC;
	localparam logic [3:0] HI_PRESSURE  = 4'hD;
	localparam logic [3:0] HI_SYSTEM    = 4'hF;

	// Parser phase, one-hot.
	typedef enum logic [5:0] {
		PH_DELTA   = 6'b000001,
		PH_STATUS  = 6'b000010,
		PH_META    = 6'b000100,
		PH_LEN     = 6'b001000,
		PH_PAYLOAD = 6'b010000,
		PH_ERROR   = 6'b100000
	} phase_t;

	// True for a channel voice status byte (0x80 to 0xEF).
	function automatic logic is_channel(input logic [7:0] b);
		is_channel = b[7] && (b[7:4] != HI_SYSTEM);
	endfunction

endpackage

[rtl/smf_event_byte_parser_core.sv]
// Top level of the track event byte parser: frames delta time, status and event bodies
// one byte at a time, with an input and a result register. Depends on smf_pkg.
// An accepted item passes through the input register and then the result register, where it is offered.
// Throughput: one item per cycle unless m_tready stalls; the single parser state update per byte sets it.
// Reset (arst_n low): phase returns to delta time, the accumulator, status and the sticky error
// clear, the remaining-byte count reloads to VLQ_BUDGET, and both register stages empty.
module smf_event_byte_parser_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,  // [7:0] byte_in
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [smf_pkg::TDATA_W-1:0]    m_tdata,  // [27:0] delta_ticks,
	                                                 // [35:28] event_status,
	                                                 // [63:36] payload_length
	output logic                           m_tlast,  // event_done
	output logic [smf_pkg::TUSER_W-1:0]    m_tuser   // [2:0] field_kind,
	                                                 // [3] parse_error
);
	import smf_pkg::*;

	localparam logic [VAL_W-1:0] VLQ_BUDGET = VAL_W'(VLQ_MAX_BYTES);

	// Input stage.
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;

	// Parser state.
	phase_t           phase_q, phase_d;
	logic [VAL_W-1:0] acc_q, acc_d;
	logic [VAL_W-1:0] rem_q, rem_d;
	logic [7:0]       run_st_q, run_st_d;
	logic [7:0]       cur_st_q, cur_st_d;
	logic [VAL_W-1:0] dhold_q, dhold_d;

	// Result of the byte in the input stage.
	logic [KIND_W-1:0] kind;
	logic              done;
	logic              err;
	logic [TDATA_W-1:0] res_data;
	logic [TUSER_W-1:0] res_user;
	logic               res_last;

	// Status decoding helpers.
	logic [7:0]       eff_st;
	logic [1:0]       n_data;
	logic [VAL_W-1:0] acc_shift;

	// The stage moves on when the result register is free or being drained.
	assign advance  = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	assign acc_shift = {acc_q[VAL_W-8:0], byte_s1[6:0]};

	// Effective status and the number of data bytes still to come.
	always_comb begin
		if (byte_s1[7]) begin
			eff_st = byte_s1;
		end else if (is_channel(run_st_q)) begin
			eff_st = run_st_q;
		end else begin
			eff_st = byte_s1;
		end
		if (eff_st[7:4] == HI_PROGRAM || eff_st[7:4] == HI_PRESSURE) begin
			n_data = 2'd1;
		end else begin
			n_data = 2'd2;
		end
		if (!byte_s1[7]) begin
			n_data = n_data - 2'd1;
		end
	end

	// Next state and result for one byte.
	always_comb begin
		phase_d  = phase_q;
		acc_d    = acc_q;
		rem_d    = rem_q;
		run_st_d = run_st_q;
		cur_st_d = cur_st_q;
		dhold_d  = dhold_q;
		kind     = KIND_DELTA;
		done     = 1'b0;
		err      = 1'b0;
		case (phase_q)
			PH_DELTA: begin
				kind = KIND_DELTA;
				if (rem_q == '0) begin
					err = 1'b1;
				end else begin
					acc_d   = acc_shift;
					rem_d   = rem_q - VAL_W'(1);
					dhold_d = acc_shift;
					if (byte_s1[7]) begin
						err = (rem_q == VAL_W'(1));
					end else begin
						phase_d = PH_STATUS;
						acc_d   = '0;
					end
				end
			end
			PH_STATUS: begin
				if (is_channel(byte_s1)) begin
					run_st_d = byte_s1;
				end else if (byte_s1[7:4] == HI_SYSTEM) begin
					run_st_d = '0;
				end
				kind = byte_s1[7] ? KIND_STATUS : KIND_PAYLOAD;
				if (is_channel(eff_st)) begin
					cur_st_d = eff_st;
					if (n_data == 2'd0) begin
						done = 1'b1;
					end else begin
						rem_d   = VAL_W'(n_data);
						phase_d = PH_PAYLOAD;
					end
				end else if (eff_st == ST_META) begin
					cur_st_d = eff_st;
					phase_d  = PH_META;
				end else if (eff_st == ST_SYSEX || eff_st == ST_SYSEX_ESC) begin
					cur_st_d = eff_st;
					phase_d  = PH_LEN;
					rem_d    = VLQ_BUDGET;
					acc_d    = '0;
				end else begin
					err = 1'b1;
				end
			end
			PH_META: begin
				kind    = KIND_META;
				phase_d = PH_LEN;
				rem_d   = VLQ_BUDGET;
				acc_d   = '0;
			end
			PH_LEN: begin
				kind = KIND_LENGTH;
				if (rem_q == '0) begin
					err = 1'b1;
				end else begin
					acc_d = acc_shift;
					rem_d = rem_q - VAL_W'(1);
					if (byte_s1[7]) begin
						err = (rem_q == VAL_W'(1));
					end else if (acc_shift != '0) begin
						phase_d = PH_PAYLOAD;
						rem_d   = acc_shift;
					end else begin
						done = 1'b1;
					end
				end
			end
			PH_PAYLOAD: begin
				kind = KIND_PAYLOAD;
				if (rem_q <= VAL_W'(1)) begin
					rem_d = '0;
					done  = 1'b1;
				end else begin
					rem_d = rem_q - VAL_W'(1);
				end
			end
			default: begin
				err = 1'b1;
			end
		endcase

		// Result fields, taken from the updated values.
		if (phase_q == PH_ERROR) begin
			res_data = '0;
			res_user = {1'b1, KIND_DELTA};
			res_last = 1'b0;
		end else begin
			res_data = {(kind >= KIND_LENGTH) ? acc_d : VAL_W'(0), cur_st_d, dhold_d};
			res_user = {err, kind};
			res_last = done && !err;
		end

		// Error parks the parser; a finished event rearms it.
		if (err) begin
			phase_d = PH_ERROR;
		end else if (done) begin
			phase_d  = PH_DELTA;
			acc_d    = '0;
			rem_d    = VLQ_BUDGET;
			cur_st_d = '0;
			dhold_d  = '0;
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_DELTA;
			acc_q    <= '0;
			rem_q    <= VLQ_BUDGET;
			run_st_q <= '0;
			cur_st_q <= '0;
			dhold_q  <= '0;
		end else if (valid_s1 && advance) begin
			phase_q  <= phase_d;
			acc_q    <= acc_d;
			rem_q    <= rem_d;
			run_st_q <= run_st_d;
			cur_st_q <= cur_st_d;
			dhold_q  <= dhold_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			m_tdata <= res_data;
			m_tuser <= res_user;
			m_tlast <= res_last;
		end
	end

	// The error phase is only left through reset.
	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ERROR |=> phase_q == PH_ERROR)
		else $error("parser left the error phase");

	// An item that closes an event never carries the error flag.
	a_done_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> !m_tuser[TUSER_W-1])
		else $error("event end reported together with an error");

	// Payload length is only shown on length and payload items.
	a_len_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[KIND_W-1:0] == KIND_DELTA || m_tuser[KIND_W-1:0] == KIND_STATUS
			|| m_tuser[KIND_W-1:0] == KIND_META) |-> m_tdata[TDATA_W-1:36] == '0)
		else $error("payload length shown on a header item");

	// A new event after completion starts with cleared delta time.
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && res_last |=> phase_q == PH_DELTA && dhold_q == '0)
		else $error("parser not rearmed after event end");

endmodule
